// ===== rtl/stt_pkg.sv =====
// shared codes and default sizes for the software timer table
package stt_pkg;

    localparam int NUM_TIMERS_DEF = 16;
    localparam int COUNT_BITS_DEF = 16;

    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_REMOVE  = 3'd2;
    localparam logic [2:0] OP_ENABLE  = 3'd3;
    localparam logic [2:0] OP_DISABLE = 3'd4;
    localparam logic [2:0] OP_SETPER  = 3'd5;
    localparam logic [2:0] OP_RESTART = 3'd6;
    localparam logic [2:0] OP_QUERY   = 3'd7;

    localparam logic [1:0] KIND_REPLY   = 2'd0;
    localparam logic [1:0] KIND_FIRED   = 2'd1;
    localparam logic [1:0] KIND_TICKEND = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_INVALID  = 2'd3;

endpackage

// ===== rtl/software_timer_table.sv =====
// software timer table: an add/remove/enable/disable/set-period/restart/query/tick sequencer over one entry memory
// steps: invalid-id and empty-table replies go straight to the reply state; add writes the entry, then
// replies; searches read and evaluate each entry visited; tick reads and evaluates each stored entry;
// remove also moves each later entry down by a read and a write; a stalled output holds the sequencer
// transactions: one at a time; the next is not accepted until the current one is finished
// reset: asynchronous, entry count and tick count go to zero; entry memory is not cleared
// input stall stays high until the reply or tick-finished result enters the output register
module software_timer_table
    import stt_pkg::*;
#(
    parameter int NUM_TIMERS = NUM_TIMERS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  op,
    input  logic [7:0]  timer_id,
    input  logic [15:0] period,
    input  logic        has_action,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  kind,
    output logic [1:0]  status,
    output logic [3:0]  slot,
    output logic [7:0]  fired_id,
    output logic [15:0] remaining,
    output logic [31:0] system_time,
    output logic        last
);

    localparam int CNT_W = $clog2(NUM_TIMERS + 1);
    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    typedef struct packed {
        logic [7:0]            tag;
        logic [COUNT_BITS-1:0] period;
        logic [COUNT_BITS-1:0] count;
        logic                  enabled;
        logic                  action;
    } entry_t;

    typedef enum logic [2:0] {
        S_IDLE, S_ADD, S_READ, S_EVAL, S_SHRD, S_SHWR, S_REPLY, S_FINAL
    } state_t;

    state_t                state_reg;
    logic [2:0]            op_reg;
    logic [7:0]            tag_reg;
    logic [COUNT_BITS-1:0] per_reg;
    logic                  act_reg;
    logic [CNT_W-1:0]      idx_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [31:0]           time_reg;
    logic                  found_reg;
    logic [IDX_W-1:0]      pos_reg;
    logic [COUNT_BITS-1:0] rem_reg;
    logic [1:0]            rpl_status_reg;
    logic [7:0]            rpl_id_reg;

    logic                  out_valid_reg;
    logic [1:0]            kind_reg;
    logic [1:0]            status_reg;
    logic [3:0]            slot_reg;
    logic [7:0]            id_reg;
    logic [15:0]           remaining_reg;
    logic [31:0]           time_out_reg;
    logic                  last_reg;

    entry_t                mem [NUM_TIMERS];
    entry_t                rd_reg;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_addr;
    entry_t                wr_data;

    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      idx_dec;
    logic                  out_free;
    logic                  out_load;
    logic                  match;
    logic                  need_fire;
    logic                  first_hit;
    logic                  scan_done;

    assign idx_inc   = idx_reg + CNT_W'(1);
    assign idx_dec   = idx_reg - CNT_W'(1);
    assign out_free  = !out_valid_reg || !out_stall;
    assign match     = (rd_reg.tag == tag_reg);
    assign need_fire = rd_reg.enabled && (rd_reg.count == '0) && rd_reg.action;
    assign first_hit = match && !found_reg;
    assign scan_done = (idx_inc == count_reg);
    assign in_stall  = (state_reg != S_IDLE);
    // a new result enters the output register this cycle
    assign out_load  = out_free && (((state_reg == S_EVAL) && (op_reg == OP_TICK) && need_fire)
                       || (state_reg == S_REPLY) || (state_reg == S_FINAL));

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = idx_reg[IDX_W-1:0];
        wr_data = rd_reg;
        case (state_reg)
            S_ADD:
            begin
                wr_en           = 1'b1;
                wr_addr         = count_reg[IDX_W-1:0];
                wr_data.tag     = tag_reg;
                wr_data.period  = per_reg;
                wr_data.count   = per_reg;
                wr_data.enabled = 1'b0;
                wr_data.action  = act_reg;
            end
            S_EVAL:
            begin
                case (op_reg)
                    OP_TICK:
                    begin
                        if (rd_reg.enabled && rd_reg.count != '0)
                        begin
                            wr_en         = 1'b1;
                            wr_data.count = rd_reg.count - COUNT_BITS'(1);
                        end
                        else if (need_fire && out_free)
                        begin
                            wr_en         = 1'b1;
                            wr_data.count = rd_reg.period;
                        end
                    end
                    OP_ENABLE, OP_DISABLE:
                    begin
                        wr_en           = match;
                        wr_data.enabled = (op_reg == OP_ENABLE);
                    end
                    OP_SETPER:
                    begin
                        wr_en          = match;
                        wr_data.period = per_reg;
                        wr_data.count  = per_reg;
                    end
                    OP_RESTART:
                    begin
                        wr_en         = match;
                        wr_data.count = rd_reg.period;
                    end
                    default:
                    begin
                        wr_en = 1'b0;
                    end
                endcase
            end
            S_SHWR:
            begin
                wr_en   = 1'b1;
                wr_addr = idx_dec[IDX_W-1:0];
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_reg <= mem[idx_reg[IDX_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            time_reg      <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= op;
                        tag_reg   <= timer_id;
                        per_reg   <= COUNT_BITS'(period);
                        act_reg   <= has_action;
                        idx_reg   <= '0;
                        found_reg <= 1'b0;
                        pos_reg   <= '0;
                        rem_reg   <= '0;
                        rpl_id_reg <= timer_id;
                        if (op == OP_TICK)
                        begin
                            state_reg <= (count_reg == '0) ? S_FINAL : S_READ;
                        end
                        else if (timer_id == 8'd0)
                        begin
                            rpl_status_reg <= ST_INVALID;
                            rpl_id_reg     <= 8'd0;
                            state_reg      <= S_REPLY;
                        end
                        else if (op == OP_ADD)
                        begin
                            if (count_reg == CNT_W'(NUM_TIMERS))
                            begin
                                rpl_status_reg <= ST_FULL;
                                state_reg      <= S_REPLY;
                            end
                            else
                            begin
                                state_reg <= S_ADD;
                            end
                        end
                        else if (count_reg == '0)
                        begin
                            rpl_status_reg <= ST_NOTFOUND;
                            state_reg      <= S_REPLY;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_ADD:
                begin
                    rpl_status_reg <= ST_OK;
                    pos_reg        <= count_reg[IDX_W-1:0];
                    rem_reg        <= per_reg;
                    count_reg      <= count_reg + CNT_W'(1);
                    state_reg      <= S_REPLY;
                end
                S_READ:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    case (op_reg)
                        OP_TICK:
                        begin
                            if (!(need_fire && !out_free))
                            begin
                                if (need_fire)
                                begin
                                    kind_reg      <= KIND_FIRED;
                                    status_reg    <= ST_OK;
                                    slot_reg      <= 4'(idx_reg);
                                    id_reg        <= rd_reg.tag;
                                    remaining_reg <= 16'(rd_reg.period);
                                    time_out_reg  <= time_reg + 32'd1;
                                    last_reg      <= 1'b0;
                                end
                                idx_reg   <= idx_inc;
                                state_reg <= scan_done ? S_FINAL : S_READ;
                            end
                        end
                        OP_ENABLE, OP_DISABLE:
                        begin
                            // every match changes, the first one is reported
                            if (first_hit)
                            begin
                                found_reg <= 1'b1;
                                pos_reg   <= idx_reg[IDX_W-1:0];
                                rem_reg   <= rd_reg.count;
                            end
                            idx_reg <= idx_inc;
                            if (scan_done)
                            begin
                                rpl_status_reg <= (found_reg || match) ? ST_OK : ST_NOTFOUND;
                                state_reg      <= S_REPLY;
                            end
                            else
                            begin
                                state_reg <= S_READ;
                            end
                        end
                        default:
                        begin
                            if (match)
                            begin
                                rpl_status_reg <= ST_OK;
                                pos_reg        <= idx_reg[IDX_W-1:0];
                                case (op_reg)
                                    OP_SETPER:  rem_reg <= per_reg;
                                    OP_RESTART: rem_reg <= rd_reg.period;
                                    default:    rem_reg <= rd_reg.count;
                                endcase
                                if (op_reg == OP_REMOVE && !scan_done)
                                begin
                                    idx_reg   <= idx_inc;
                                    state_reg <= S_SHRD;
                                end
                                else
                                begin
                                    if (op_reg == OP_REMOVE)
                                    begin
                                        count_reg <= count_reg - CNT_W'(1);
                                    end
                                    state_reg <= S_REPLY;
                                end
                            end
                            else
                            begin
                                idx_reg <= idx_inc;
                                if (scan_done)
                                begin
                                    rpl_status_reg <= ST_NOTFOUND;
                                    state_reg      <= S_REPLY;
                                end
                                else
                                begin
                                    state_reg <= S_READ;
                                end
                            end
                        end
                    endcase
                end
                S_SHRD:
                begin
                    state_reg <= S_SHWR;
                end
                S_SHWR:
                begin
                    // entry idx moved down to idx-1
                    if (scan_done)
                    begin
                        count_reg <= count_reg - CNT_W'(1);
                        state_reg <= S_REPLY;
                    end
                    else
                    begin
                        idx_reg   <= idx_inc;
                        state_reg <= S_SHRD;
                    end
                end
                S_REPLY:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_REPLY;
                        status_reg    <= rpl_status_reg;
                        slot_reg      <= (rpl_status_reg == ST_OK) ? 4'(pos_reg) : 4'd0;
                        id_reg        <= rpl_id_reg;
                        remaining_reg <= (rpl_status_reg == ST_OK) ? 16'(rem_reg) : 16'd0;
                        time_out_reg  <= time_reg;
                        last_reg      <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                S_FINAL:
                begin
                    if (out_free)
                    begin
                        kind_reg      <= KIND_TICKEND;
                        status_reg    <= ST_OK;
                        slot_reg      <= 4'd0;
                        id_reg        <= 8'd0;
                        remaining_reg <= 16'd0;
                        time_out_reg  <= time_reg + 32'd1;
                        last_reg      <= 1'b1;
                        time_reg      <= time_reg + 32'd1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign status      = status_reg;
    assign slot        = slot_reg;
    assign fired_id    = id_reg;
    assign remaining   = remaining_reg;
    assign system_time = time_out_reg;
    assign last        = last_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(NUM_TIMERS))
        else $error("entry count above table size");

    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < NUM_TIMERS))
        else $error("memory write outside table");

    a_not_last_is_fire: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !last_reg) |-> (kind_reg == KIND_FIRED))
        else $error("non-final result is not a fire");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !wr_en)
        else $error("memory written while idle");

endmodule

// ===== tb/software_timer_table_test.sv =====
// self-checking testbench for the software timer table
`timescale 1ns / 1ps

class timer_scoreboard;
    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [7:0]  fired_id;
        logic [15:0] remaining;
        logic [31:0] system_time;
        logic        last;
    } result_t;

    typedef struct {
        logic [7:0]  tag;
        logic [15:0] per;
        logic [15:0] count;
        logic        enabled;
        logic        action;
    } entry_t;

    entry_t      entries[16];
    int          entry_count;
    logic [31:0] tick_total;
    result_t     pending[$];
    int          errors;

    function new();
        entry_count = 0;
        tick_total = 0;
        errors = 0;
    endfunction

    function void push(logic [1:0] k, logic [1:0] s, int sl, logic [7:0] id,
                       logic [15:0] rem, logic [31:0] t, logic l);
        result_t r;
        r.kind = k;
        r.status = s;
        r.slot = sl[3:0];
        r.fired_id = id;
        r.remaining = rem;
        r.system_time = t;
        r.last = l;
        pending.push_back(r);
    endfunction

    function int find_first(logic [7:0] tag);
        for (int i = 0; i < entry_count; i++)
            if (entries[i].tag == tag)
                return i;
        return -1;
    endfunction

    // predict the results of one accepted input transaction
    function void note_input(logic [2:0] op, logic [7:0] tag, logic [15:0] per,
                             logic act);
        int pos;
        logic [31:0] now;
        logic [15:0] rem;
        if (op == stt_pkg::OP_TICK)
        begin
            now = tick_total + 1;
            for (int i = 0; i < entry_count; i++)
            begin
                if (!entries[i].enabled)
                    continue;
                if (entries[i].count != 0)
                    entries[i].count = entries[i].count - 1;
                else if (entries[i].action)
                begin
                    entries[i].count = entries[i].per;
                    push(stt_pkg::KIND_FIRED, stt_pkg::ST_OK, i, entries[i].tag,
                         entries[i].count, now, 1'b0);
                end
            end
            tick_total = now;
            push(stt_pkg::KIND_TICKEND, stt_pkg::ST_OK, 0, 8'd0, 16'd0, now, 1'b1);
            return;
        end
        if (tag == 0)
        begin
            push(stt_pkg::KIND_REPLY, stt_pkg::ST_INVALID, 0, 8'd0, 16'd0, tick_total, 1'b1);
            return;
        end
        if (op == stt_pkg::OP_ADD)
        begin
            if (entry_count >= 16)
            begin
                push(stt_pkg::KIND_REPLY, stt_pkg::ST_FULL, 0, tag, 16'd0, tick_total, 1'b1);
                return;
            end
            entries[entry_count].tag = tag;
            entries[entry_count].per = per;
            entries[entry_count].count = per;
            entries[entry_count].enabled = 1'b0;
            entries[entry_count].action = act;
            push(stt_pkg::KIND_REPLY, stt_pkg::ST_OK, entry_count, tag, per,
                 tick_total, 1'b1);
            entry_count++;
            return;
        end
        pos = find_first(tag);
        if (pos < 0)
        begin
            push(stt_pkg::KIND_REPLY, stt_pkg::ST_NOTFOUND, 0, tag, 16'd0, tick_total, 1'b1);
            return;
        end
        case (op)
            stt_pkg::OP_REMOVE:
            begin
                rem = entries[pos].count;
                for (int i = pos; i + 1 < entry_count; i++)
                    entries[i] = entries[i + 1];
                entry_count--;
                push(stt_pkg::KIND_REPLY, stt_pkg::ST_OK, pos, tag, rem, tick_total, 1'b1);
                return;
            end
            stt_pkg::OP_ENABLE, stt_pkg::OP_DISABLE:
                for (int i = 0; i < entry_count; i++)
                    if (entries[i].tag == tag)
                        entries[i].enabled = (op == stt_pkg::OP_ENABLE);
            stt_pkg::OP_SETPER:
            begin
                entries[pos].per = per;
                entries[pos].count = per;
            end
            stt_pkg::OP_RESTART:
                entries[pos].count = entries[pos].per;
            default:
                ;
        endcase
        push(stt_pkg::KIND_REPLY, stt_pkg::ST_OK, pos, tag, entries[pos].count,
             tick_total, 1'b1);
    endfunction

    function void check_result(result_t got);
        result_t want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (got.kind != want.kind)
        begin
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
            errors++;
        end
        if (got.status != want.status)
        begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            errors++;
        end
        if (got.slot != want.slot)
        begin
            $display("%0t: slot expected %0d actual %0d", $time, want.slot, got.slot);
            errors++;
        end
        if (got.fired_id != want.fired_id)
        begin
            $display("%0t: fired_id expected %0d actual %0d", $time, want.fired_id,
                     got.fired_id);
            errors++;
        end
        if (got.remaining != want.remaining)
        begin
            $display("%0t: remaining expected %0d actual %0d", $time, want.remaining,
                     got.remaining);
            errors++;
        end
        if (got.system_time != want.system_time)
        begin
            $display("%0t: system_time expected %0d actual %0d", $time,
                     want.system_time, got.system_time);
            errors++;
        end
        if (got.last != want.last)
        begin
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
            errors++;
        end
    endfunction
endclass

module software_timer_table_test;
    import stt_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = OP_TICK;
    logic [7:0]  timer_id = 8'd0;
    logic [15:0] period = 16'd0;
    logic        has_action = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  kind;
    logic [1:0]  status;
    logic [3:0]  slot;
    logic [7:0]  fired_id;
    logic [15:0] remaining;
    logic [31:0] system_time;
    logic        last;

    timer_scoreboard board = new();
    int idle_pct = 0;
    int stall_pct = 0;

    software_timer_table u_top (.*);

    always #5 clk = ~clk;

    // receiver: random stall, check at the rising edge
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            board.check_result({kind, status, slot, fired_id, remaining, system_time, last});
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // valid stays high after acceptance until the next transaction or an idle cycle
    task automatic send(logic [2:0] o, logic [7:0] id, logic [15:0] per, logic act);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        timer_id <= id;
        period <= per;
        has_action <= act;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        board.note_input(o, id, per, act);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // mostly small tags so operations hit existing timers, small periods so they fire
    task automatic random_item();
        logic [2:0]  o;
        logic [7:0]  id;
        logic [15:0] per;
        int r;
        r = $urandom_range(99);
        if (r < 35)
            o = OP_TICK;
        else if (r < 50)
            o = OP_ADD;
        else
            o = 3'($urandom_range(7));
        id = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(6));
        per = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(4));
        send(o, id, per, 1'($urandom));
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // directed
        send(OP_TICK, 8'd0, 16'd0, 1'b0);
        send(OP_QUERY, 8'd0, 16'd0, 1'b0);
        send(OP_REMOVE, 8'd9, 16'd0, 1'b0);
        send(OP_ADD, 8'd255, 16'hFFFF, 1'b1);
        send(OP_ADD, 8'd1, 16'd0, 1'b1);
        send(OP_ADD, 8'd1, 16'd1, 1'b0);
        send(OP_ENABLE, 8'd1, 16'd0, 1'b0);
        send(OP_ENABLE, 8'd255, 16'd0, 1'b0);
        send(OP_TICK, 8'd0, 16'd0, 1'b0);
        send(OP_TICK, 8'd0, 16'd0, 1'b0);
        send(OP_SETPER, 8'd255, 16'd0, 1'b0);
        send(OP_TICK, 8'd0, 16'd0, 1'b0);
        send(OP_RESTART, 8'd1, 16'd0, 1'b0);
        send(OP_QUERY, 8'd1, 16'd0, 1'b0);
        send(OP_DISABLE, 8'd1, 16'd0, 1'b0);
        send(OP_REMOVE, 8'd1, 16'd0, 1'b0);
        for (int i = 0; i < 16; i++)
            send(OP_ADD, 8'(i + 2), 16'd2, 1'b1);
        send(OP_ENABLE, 8'd5, 16'd0, 1'b0);
        send(OP_TICK, 8'd0, 16'd0, 1'b0);
        drain();
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 31 : 59) : 0;
            stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 31 : 59) : 0;
            for (int k = 0; k < 115; k++)
                random_item();
            drain();
        end
        if (board.errors == 0 && board.pending.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== software_timer_table.f =====
rtl/stt_pkg.sv
rtl/software_timer_table.sv
tb/software_timer_table_test.sv
